FILE: hdl/tcw_pkg.sv
// Shared package for the text console writer: word types, op codes,
// character constants and the controller/datapath command and status structs.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int TCW_ROWS = 25;
  localparam int TCW_COLS = 80;

  localparam int POS_W  = 11;
  localparam int IDX_W  = 11;
  localparam int CHAR_W = 8;

  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]        operation;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
    logic              end_of_write;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic              cursor_update;
    logic [CHAR_W-1:0] read_char;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;       // take the input word
    logic exec;        // run the latched word (put/home/cursor move)
    logic capture;     // grab RAM read data for a read word
    logic fill;        // write a space at the sweep counter, step it
    logic copy;        // read at the sweep counter, step it, write one row up next cycle
    logic cnt_clr;     // sweep counter to cell 0
    logic cnt_src;     // sweep counter to first cell of row 1
    logic cnt_bottom;  // sweep counter to first cell of the bottom row
    logic out_load;    // load the result register
  } tcw_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_put;
    logic is_read;
    logic is_clear;
    logic is_nl;
    logic row_last;
    logic col_last;
    logic cnt_last;
    logic out_free;
  } tcw_stat_t;

endpackage

FILE: hdl/text_console_writer.sv
// Text console writer: ROWS x COLS character RAM with cursor, scroll and clear.
// Steps: a put is accepted, executed and its result loaded; a read adds a capture step; a
// newline or row wrap on the last row adds a scroll copy, a drain step and a bottom-row blank;
// a clear adds a sweep that writes spaces to every cell.
// One word at a time: the next word is accepted only once the previous result is loaded.
// Reset: synchronous; a sweep writes spaces to every cell before the first word.
`timescale 1ns / 1ps

module text_console_writer #(
  parameter int ROWS = tcw_pkg::TCW_ROWS,
  parameter int COLS = tcw_pkg::TCW_COLS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcw_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tcw_pkg::out_word_t out_data
);

  // Controller decides which step runs; datapath holds all storage.
  tcw_pkg::tcw_ctl_t  ctl;
  tcw_pkg::tcw_stat_t stat;

  // Sequencer: sweeps (reset, clear, bottom blank), scroll copy, read, hand-off.
  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Cursor, sweep counter, character RAM, result register.
  // The result register lets the next word in while a result waits.
  tcw_dpath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // One word at a time: accepting a word makes the block busy next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("word accepted while previous still in work");

  // A clear always reports the home position.
  a_clear_home: assert property (@(posedge clk) disable iff (rst)
    (ctl.out_load && stat.is_clear) |=> (out_data.cursor_position == '0))
    else $error("clear did not home the cursor");

  // Sweep fill and scroll copy never share a cycle.
  a_fill_copy_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctl.fill && ctl.copy))
    else $error("fill and copy issued together");

  // A result is loaded only into a free result register.
  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!out_valid || !out_stall))
    else $error("result overwritten before taken");
`endif

endmodule

FILE: hdl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/tcw_ctrl.sv
// Sequencing FSM of the text console writer: reset/clear sweeps, scroll copy,
// read capture and result hand-off. Uses tcw_pkg command/status structs.
`timescale 1ns / 1ps

module tcw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tcw_pkg::tcw_stat_t stat,
  output tcw_pkg::tcw_ctl_t  ctl
);

  typedef enum logic [8:0] {
    S_CLR_RST = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_EXEC    = 9'b000000100,
    S_READ    = 9'b000001000,
    S_SCROLL  = 9'b000010000,
    S_DRAIN   = 9'b000100000,
    S_BLANK   = 9'b001000000,
    S_CLR_OP  = 9'b010000000,
    S_RESULT  = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR_RST;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_CLR_RST: begin
        ctl.fill = 1'b1;
        if (stat.cnt_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        if (stat.is_clear) begin
          ctl.cnt_clr = 1'b1;
          state_next  = S_CLR_OP;
        end else if (stat.is_read) begin
          state_next = S_READ;
        end else if (stat.is_put && (stat.is_nl || stat.col_last) && stat.row_last) begin
          ctl.cnt_src = 1'b1;
          state_next  = S_SCROLL;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_READ: begin
        ctl.capture = 1'b1;
        state_next  = S_RESULT;
      end
      S_SCROLL: begin
        ctl.copy = 1'b1;
        if (stat.cnt_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        ctl.cnt_bottom = 1'b1;
        state_next     = S_BLANK;
      end
      S_BLANK: begin
        ctl.fill = 1'b1;
        if (stat.cnt_last) state_next = S_RESULT;
      end
      S_CLR_OP: begin
        ctl.fill = 1'b1;
        if (stat.cnt_last) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLR_RST;
      end
    endcase
  end

endmodule

FILE: hdl/tcw_dpath.sv
// Datapath of the text console writer: word register, cursor, sweep counter,
// character RAM and result register. Uses tcw_pkg and tcw_ram.
`timescale 1ns / 1ps

module tcw_dpath #(
  parameter int ROWS = tcw_pkg::TCW_ROWS,
  parameter int COLS = tcw_pkg::TCW_COLS
) (
  input  logic                clk,
  input  logic                rst,
  input  tcw_pkg::in_word_t   in_data,
  input  tcw_pkg::tcw_ctl_t   ctl,
  output tcw_pkg::tcw_stat_t  stat,
  output logic                out_valid,
  input  logic                out_stall,
  output tcw_pkg::out_word_t  out_data
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int PW    = (AW > tcw_pkg::POS_W) ? AW : tcw_pkg::POS_W;

  tcw_pkg::in_word_t item;

  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [AW-1:0] base;      // row * COLS
  logic [AW-1:0] cnt;       // sweep counter
  logic          cp_pend;
  logic [AW-1:0] cp_dst;
  logic [tcw_pkg::CHAR_W-1:0] rdchar;

  logic [AW-1:0] pos;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] idx_ext;
  logic          in_range;
  logic          advance;

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [tcw_pkg::CHAR_W-1:0] wr_data;
  logic [AW-1:0]              rd_addr;
  logic [tcw_pkg::CHAR_W-1:0] rd_data;

  assign pos      = base + AW'(col);
  assign pos_ext  = PW'(pos);
  assign idx_ext  = PW'(item.cell_index);
  assign in_range = (32'(item.cell_index) < 32'(CELLS));

  assign stat.is_put   = (item.operation == tcw_pkg::OP_PUT);
  assign stat.is_read  = (item.operation == tcw_pkg::OP_READ);
  assign stat.is_clear = (item.operation == tcw_pkg::OP_CLEAR);
  assign stat.is_nl    = (item.char_code == tcw_pkg::NEWLINE_CHAR);
  assign stat.row_last = (row == RW'(ROWS - 1));
  assign stat.col_last = (col == CW'(COLS - 1));
  assign stat.cnt_last = (cnt == AW'(CELLS - 1));
  assign stat.out_free = !out_valid || !out_stall;

  assign advance = stat.is_put && (stat.is_nl || stat.col_last);

  // RAM ports: pending copy write, sweep fill, then character put
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = item.char_code;
    if (cp_pend) begin
      wr_en   = 1'b1;
      wr_addr = cp_dst;
      wr_data = rd_data;
    end else if (ctl.fill) begin
      wr_en   = 1'b1;
      wr_addr = cnt;
      wr_data = tcw_pkg::SPACE_CHAR;
    end else if (ctl.exec && stat.is_put && !stat.is_nl) begin
      wr_en = 1'b1;
    end
  end

  assign rd_addr = ctl.copy ? cnt : idx_ext[AW-1:0];

  tcw_ram #(
    .WIDTH(tcw_pkg::CHAR_W),
    .DEPTH(CELLS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (ctl.latch) item <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row     <= '0;
      col     <= '0;
      base    <= '0;
      cnt     <= '0;
      cp_pend <= 1'b0;
    end else begin
      if (ctl.exec) begin
        if (stat.is_clear) begin
          row  <= '0;
          col  <= '0;
          base <= '0;
        end else if (advance) begin
          col <= '0;
          if (!stat.row_last) begin
            row  <= row + 1'b1;
            base <= base + AW'(COLS);
          end
        end else if (stat.is_put) begin
          col <= col + 1'b1;
        end
      end

      if (ctl.cnt_clr) begin
        cnt <= '0;
      end else if (ctl.cnt_src) begin
        cnt <= AW'(COLS);
      end else if (ctl.cnt_bottom) begin
        cnt <= AW'((ROWS - 1) * COLS);
      end else if (ctl.fill || ctl.copy) begin
        cnt <= cnt + 1'b1;
      end

      cp_pend <= ctl.copy;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.copy) cp_dst <= cnt - AW'(COLS);
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      rdchar <= '0;
    end else if (ctl.capture) begin
      rdchar <= in_range ? rd_data : '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data.cursor_position <= pos_ext[tcw_pkg::POS_W-1:0];
      out_data.cursor_update   <= (stat.is_put && item.end_of_write) || stat.is_clear;
      out_data.read_char       <= rdchar;
    end
  end

endmodule

FILE: dv/text_console_writer_chk.sv
`timescale 1ns / 1ps
// Checker for the text console writer: mirrors the character store and cursor,
// predicts one result word per accepted input word and compares them in order.
// Depends on tcw_pkg for the word types, op codes and character constants.

module text_console_writer_chk #(
  parameter int ROWS = tcw_pkg::TCW_ROWS,
  parameter int COLS = tcw_pkg::TCW_COLS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  tcw_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  tcw_pkg::out_word_t out_data,
  output int                 fail_count,
  output int                 pending
);

  localparam int CELLS = ROWS * COLS;

  logic [tcw_pkg::CHAR_W-1:0] screen [CELLS];
  int unsigned                cur_row;
  int unsigned                cur_col;
  tcw_pkg::out_word_t         due_q [$];
  int                         errs = 0;

  assign fail_count = errs;

  task automatic flag_error(input string msg);
    errs++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen[i] = tcw_pkg::SPACE_CHAR;
    cur_row = 0;
    cur_col = 0;
  endfunction

  // column 0 of the next row; on the bottom row everything moves up a line
  function automatic void line_feed();
    cur_col = 0;
    if (cur_row == ROWS - 1) begin
      for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = tcw_pkg::SPACE_CHAR;
    end else begin
      cur_row++;
    end
  endfunction

  function automatic tcw_pkg::out_word_t console_step(input tcw_pkg::in_word_t w);
    tcw_pkg::out_word_t r;
    int unsigned        pos_full;
    r = '0;
    case (w.operation)
      tcw_pkg::OP_PUT: begin
        if (w.char_code == tcw_pkg::NEWLINE_CHAR) begin
          line_feed();
        end else begin
          screen[cur_row * COLS + cur_col] = w.char_code;
          cur_col++;
          if (cur_col == COLS) line_feed();
        end
        r.cursor_update = w.end_of_write;
      end
      tcw_pkg::OP_READ: begin
        if (w.cell_index < CELLS) r.read_char = screen[w.cell_index];
      end
      tcw_pkg::OP_CLEAR: begin
        blank_screen();
        r.cursor_update = 1'b1;
      end
      default: ;  // unused code leaves everything alone
    endcase
    pos_full = cur_row * COLS + cur_col;
    r.cursor_position = pos_full[tcw_pkg::POS_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    tcw_pkg::out_word_t want;
    if (rst) begin
      blank_screen();
      due_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          flag_error($sformatf("result word %h with nothing expected", out_data));
        end else begin
          want = due_q.pop_front();
          if (out_data.cursor_position !== want.cursor_position)
            flag_error($sformatf("cursor_position %0d, expected %0d",
                                 out_data.cursor_position, want.cursor_position));
          if (out_data.cursor_update !== want.cursor_update)
            flag_error($sformatf("cursor_update %b, expected %b",
                                 out_data.cursor_update, want.cursor_update));
          if (out_data.read_char !== want.read_char)
            flag_error($sformatf("read_char %h, expected %h",
                                 out_data.read_char, want.read_char));
        end
      end
      if (in_valid && !in_stall) due_q.push_back(console_step(in_data));
    end
    pending <= due_q.size();
  end

endmodule

FILE: dv/text_console_writer_tb.sv
`timescale 1ns / 1ps
// Testbench top for the text console writer: clock, reset, word stimulus,
// output stall pattern and the verdict. Depends on tcw_pkg and the checker.

module text_console_writer_tb;

  localparam logic [1:0] OP_NONE = 2'd3;  // unused op code, block must ignore it

  localparam int ITEM_TARGET = 1950;
  localparam int HOLD_CYCLES = 600;   // long output hold-off, fills the block
  localparam int TAIL_CYCLES = 2100;  // a bit more than one scroll or clear pass
  localparam int LIMIT_NS    = 200_000_000;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  tcw_pkg::in_word_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  tcw_pkg::out_word_t out_data;

  int fail_count;
  int pending;

  // receiver control, written by the stimulus process with NBAs
  int stall_pct = 0;
  int hold_seq  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // stimulus bookkeeping
  int sent     = 0;
  int idle_pct = 0;

  always #5 clk = ~clk;

  text_console_writer u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  text_console_writer_chk u_chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver. A bump of hold_seq starts a long hold-off counted here; otherwise
  // stall at random with the current percentage (zero means never).
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(1, 100) <= stall_pct);
    end
  end

  function automatic tcw_pkg::in_word_t word_of(input logic [1:0] op, input logic [7:0] ch,
                                                input logic [10:0] idx, input logic eow);
    tcw_pkg::in_word_t w;
    w.operation    = op;
    w.char_code    = ch;
    w.cell_index   = idx;
    w.end_of_write = eow;
    return w;
  endfunction

  // random content in every field; callers override what matters
  function automatic tcw_pkg::in_word_t any_word(input logic [1:0] op);
    return word_of(op, 8'($urandom), 11'($urandom), 1'($urandom));
  endfunction

  // Offer one word, maybe after a random idle gap, and hold it until it is
  // taken. Valid stays high on return so back-to-back words need no toggle.
  task automatic send_word(input tcw_pkg::in_word_t w);
    while (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Drop valid and wait until the checker has nothing outstanding. The first
  // edge lets the count catch up with a word taken at the current edge.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    tcw_pkg::in_word_t w;
    int                phase;
    int                cur_phase;
    int                pick;
    int                len;
    int                nl_pct;

    cur_phase = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed words. The store comes out of reset all spaces, so the first
    // reads check the clearing pass too.
    send_word(word_of(tcw_pkg::OP_READ,  8'h00, 11'd0,    1'b0));
    send_word(word_of(tcw_pkg::OP_READ,  8'hFF, 11'd1999, 1'b1));  // last cell, flag ignored
    send_word(word_of(tcw_pkg::OP_PUT,   8'h00, 11'd0,    1'b0));  // lowest character
    send_word(word_of(tcw_pkg::OP_PUT,   8'hFF, 11'd2047, 1'b1));  // highest, ends a write
    send_word(word_of(tcw_pkg::OP_READ,  8'h00, 11'd0,    1'b0));
    send_word(word_of(tcw_pkg::OP_READ,  8'h00, 11'd1,    1'b0));
    send_word(word_of(tcw_pkg::OP_READ,  8'hFF, 11'd2000, 1'b1));  // first index past store
    send_word(word_of(tcw_pkg::OP_READ,  8'h00, 11'd2047, 1'b0));  // top of the index field
    send_word(word_of(OP_NONE,           8'hFF, 11'd2047, 1'b1));  // unused op, flag ignored
    send_word(word_of(OP_NONE,           8'h00, 11'd0,    1'b0));
    send_word(word_of(tcw_pkg::OP_PUT,   tcw_pkg::NEWLINE_CHAR, 11'd0, 1'b0));
    send_word(word_of(tcw_pkg::OP_PUT,   8'h41, 11'd0,    1'b1));  // row 1, column 0
    send_word(word_of(tcw_pkg::OP_READ,  8'h00, 11'd80,   1'b0));
    send_word(word_of(tcw_pkg::OP_PUT,   tcw_pkg::NEWLINE_CHAR, 11'd0, 1'b1));  // ends a write
    send_word(word_of(tcw_pkg::OP_CLEAR, 8'h00, 11'd0,    1'b0));
    send_word(word_of(tcw_pkg::OP_READ,  8'h00, 11'd1,    1'b0));  // blank again after clear
    send_word(word_of(tcw_pkg::OP_READ,  8'h00, 11'd80,   1'b0));
    send_word(word_of(tcw_pkg::OP_PUT,   8'h5A, 11'd0,    1'b1));  // cursor back from home

    // Sender pauses until the block is empty, then the receiver goes into a
    // long hold-off while words keep coming, so the block backs up its input.
    wait_drained();
    hold_seq <= hold_seq + 1;

    // Random part in four idling phases, drained between phases:
    //   0 no idling, 1 sender idle, 2 receiver stalls, 3 both.
    // Most of it is write requests (runs of puts ending with the end flag)
    // so the cursor wraps rows and the screen scrolls; the rest is reads,
    // the odd clear and unused op codes.
    while (sent < ITEM_TARGET) begin
      phase = sent * 4 / ITEM_TARGET;
      if (phase != cur_phase) begin
        cur_phase = phase;
        wait_drained();
        case (phase)
          1:       begin idle_pct = 45; stall_pct <= 0;  end
          2:       begin idle_pct = 0;  stall_pct <= 45; end
          default: begin idle_pct = 34; stall_pct <= 34; end
        endcase
      end

      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_word(any_word(tcw_pkg::OP_CLEAR));
      end else if (pick < 12) begin
        w = any_word(tcw_pkg::OP_READ);
        // mostly inside the store, now and then past its end
        w.cell_index = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(2000, 2047))
                                                   : 11'($urandom_range(0, 1999));
        send_word(w);
      end else if (pick < 15) begin
        send_word(any_word(OP_NONE));
      end else begin
        // Short requests are the norm; long ones without newlines fill rows
        // and wrap, also on the bottom row where the wrap scrolls.
        len    = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                             : $urandom_range(1, 24);
        nl_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 15);
        for (int k = 0; k < len; k++) begin
          w = any_word(tcw_pkg::OP_PUT);
          if ($urandom_range(1, 100) <= nl_pct) w.char_code = tcw_pkg::NEWLINE_CHAR;
          w.end_of_write = (k == len - 1);
          send_word(w);
        end
      end
    end

    // everything offered: wait for the last results, then watch for strays
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // hard stop in case the block hangs or drops a word
  initial begin
    #LIMIT_NS;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_ctrl.sv
hdl/tcw_dpath.sv
hdl/text_console_writer.sv
dv/text_console_writer_chk.sv
dv/text_console_writer_tb.sv
